// ----- sv/u2a_pkg.sv -----
// Package for the UTF-8 Latin to ASCII folder: fold table, phase codes, queue entry types.
// No dependencies.
`default_nettype none
package u2a_pkg;

    localparam int QueueDepth = 4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEAD = 2'd1,
        PH_E2   = 2'd2,
        PH_E280 = 2'd3
    } phase_t;

    // Up to three bytes of one input transaction.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            eot;
    } seq_t;

    // Fold entry: two characters, 0 means absent.
    typedef logic [15:0] fold_t;

    function automatic fold_t fold_lookup(input logic [1:0] sel, input logic [5:0] idx);
        fold_t r;
        r = 16'h0000;
        unique case (sel)
            2'd0:
            begin
                unique case (idx)
                    6'h00, 6'h01, 6'h02, 6'h03, 6'h05: r = {"A", 8'h00};
                    6'h04: r = "Ae";
                    6'h06: r = "AE";
                    6'h07: r = {"C", 8'h00};
                    6'h08, 6'h09, 6'h0a, 6'h0b: r = {"E", 8'h00};
                    6'h0c, 6'h0d, 6'h0e, 6'h0f: r = {"I", 8'h00};
                    6'h10: r = {"D", 8'h00};
                    6'h11: r = {"N", 8'h00};
                    6'h12, 6'h13, 6'h14, 6'h15, 6'h18: r = {"O", 8'h00};
                    6'h16: r = "Oe";
                    6'h17: r = {"x", 8'h00};
                    6'h19, 6'h1a, 6'h1b: r = {"U", 8'h00};
                    6'h1c: r = "Ue";
                    6'h1d: r = {"Y", 8'h00};
                    6'h1f: r = "ss";
                    6'h20, 6'h21, 6'h22, 6'h23, 6'h25: r = {"a", 8'h00};
                    6'h24, 6'h26: r = "ae";
                    6'h27: r = {"c", 8'h00};
                    6'h28, 6'h29, 6'h2a, 6'h2b: r = {"e", 8'h00};
                    6'h2c, 6'h2d, 6'h2e, 6'h2f: r = {"i", 8'h00};
                    6'h30: r = {"d", 8'h00};
                    6'h31: r = {"n", 8'h00};
                    6'h32, 6'h33, 6'h34, 6'h35, 6'h38: r = {"o", 8'h00};
                    6'h36: r = "oe";
                    6'h39, 6'h3a, 6'h3b: r = {"u", 8'h00};
                    6'h3c: r = "ue";
                    6'h3d, 6'h3f: r = {"y", 8'h00};
                    default: r = 16'h0000;
                endcase
            end
            2'd1:
            begin
                if (idx <= 6'h05)
                    r = {(idx[0] ? "a" : "A"), 8'h00};
                else if (idx <= 6'h0d)
                    r = {(idx[0] ? "c" : "C"), 8'h00};
                else if (idx <= 6'h11)
                    r = {(idx[0] ? "d" : "D"), 8'h00};
                else if (idx <= 6'h1b)
                    r = {(idx[0] ? "e" : "E"), 8'h00};
                else if (idx <= 6'h23)
                    r = {(idx[0] ? "g" : "G"), 8'h00};
                else if (idx <= 6'h27)
                    r = {(idx[0] ? "h" : "H"), 8'h00};
                else if (idx <= 6'h31)
                    r = {(idx[0] ? "i" : "I"), 8'h00};
                else if (idx == 6'h32)
                    r = "IJ";
                else if (idx == 6'h33)
                    r = "ij";
                else if (idx <= 6'h35)
                    r = {(idx[0] ? "j" : "J"), 8'h00};
                else if (idx == 6'h36)
                    r = {"K", 8'h00};
                else if (idx <= 6'h38)
                    r = {"k", 8'h00};
                else
                    r = {(idx[0] ? "L" : "l"), 8'h00};
            end
            2'd2:
            begin
                if (idx == 6'h00)
                    r = {"l", 8'h00};
                else if (idx <= 6'h02)
                    r = {(idx[0] ? "L" : "l"), 8'h00};
                else if (idx <= 6'h08)
                    r = {(idx[0] ? "N" : "n"), 8'h00};
                else if (idx <= 6'h0b)
                    r = 16'h0000;
                else if (idx <= 6'h11)
                    r = {(idx[0] ? "o" : "O"), 8'h00};
                else if (idx == 6'h12)
                    r = "OE";
                else if (idx == 6'h13)
                    r = "oe";
                else if (idx <= 6'h19)
                    r = {(idx[0] ? "r" : "R"), 8'h00};
                else if (idx <= 6'h21)
                    r = {(idx[0] ? "s" : "S"), 8'h00};
                else if (idx <= 6'h27)
                    r = {(idx[0] ? "t" : "T"), 8'h00};
                else if (idx <= 6'h33)
                    r = {(idx[0] ? "u" : "U"), 8'h00};
                else if (idx <= 6'h35)
                    r = {(idx[0] ? "w" : "W"), 8'h00};
                else if (idx <= 6'h37)
                    r = {(idx[0] ? "y" : "Y"), 8'h00};
                else if (idx == 6'h38)
                    r = {"Y", 8'h00};
                else if (idx <= 6'h3e)
                    r = {(idx[0] ? "Z" : "z"), 8'h00};
                else
                    r = 16'h0000;
            end
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/u2a_front.sv -----
// Front end: accepts bytes, tracks held lead bytes, emits up to three bytes per transaction.
// Depends on u2a_pkg.
`default_nettype none
module u2a_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    in_byte,
    input  wire logic          end_of_text,
    input  wire logic          take,
    output u2a_pkg::seq_t      seq
);
    import u2a_pkg::*;

    logic [7:0] held_lead_reg, held_lead_next;
    phase_t     phase_reg, phase_next;
    seq_t       s;
    fold_t      f;
    logic [1:0] lsel;
    logic       fresh;

    function automatic seq_t add(input seq_t q, input logic [7:0] b);
        seq_t r;
        r = q;
        r.bytes[q.cnt] = b;
        r.cnt = q.cnt + 2'd1;
        return r;
    endfunction

    assign lsel = held_lead_reg[1:0] - 2'd3;
    assign f = fold_lookup(lsel, in_byte[5:0]);

    always_comb
    begin
        s = '0;
        s.eot = end_of_text;
        held_lead_next = held_lead_reg;
        phase_next = phase_reg;
        fresh = 1'b0;
        unique case (phase_reg)
            PH_IDLE: fresh = 1'b1;
            PH_LEAD:
            begin
                phase_next = PH_IDLE;
                if (held_lead_reg == 8'hC2 && in_byte == 8'hA0)
                    s = add(s, 8'h20);
                else if (held_lead_reg != 8'hC2 && in_byte[7:6] == 2'b10
                         && f[15:8] != 8'h00)
                begin
                    s = add(s, f[15:8]);
                    if (f[7:0] != 8'h00)
                        s = add(s, f[7:0]);
                end
                else
                begin
                    s = add(s, held_lead_reg);
                    fresh = 1'b1;
                end
            end
            PH_E2:
            begin
                if (in_byte == 8'h80)
                    phase_next = PH_E280;
                else
                begin
                    s = add(s, 8'hE2);
                    phase_next = PH_IDLE;
                    fresh = 1'b1;
                end
            end
            PH_E280:
            begin
                phase_next = PH_IDLE;
                if (in_byte == 8'hAF)
                    s = add(s, 8'h20);
                else
                begin
                    s = add(s, 8'hE2);
                    s = add(s, 8'h80);
                    fresh = 1'b1;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
        if (fresh)
        begin
            if (in_byte >= 8'hC2 && in_byte <= 8'hC5)
            begin
                held_lead_next = in_byte;
                phase_next = PH_LEAD;
            end
            else if (in_byte == 8'hE2)
            begin
                held_lead_next = in_byte;
                phase_next = PH_E2;
            end
            else
                s = add(s, in_byte);
        end
        if (end_of_text)
        begin
            if (phase_next == PH_LEAD || phase_next == PH_E2)
                s = add(s, held_lead_next);
            else if (phase_next == PH_E280)
            begin
                s = add(s, 8'hE2);
                s = add(s, 8'h80);
            end
            phase_next = PH_IDLE;
            held_lead_next = 8'h00;
        end
    end

    assign seq = s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg <= 8'h00;
            phase_reg <= PH_IDLE;
        end
        else if (push && take)
        begin
            held_lead_reg <= held_lead_next;
            phase_reg <= phase_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/u2a_queue.sv -----
// Short queue of byte groups between front and back.
// Depends on u2a_pkg.
`default_nettype none
module u2a_queue #(
    parameter int Depth = u2a_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire u2a_pkg::seq_t wdata,
    output logic               full,
    output logic               nonempty,
    input  wire logic          rd,
    output u2a_pkg::seq_t      rdata
);
    import u2a_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    seq_t            mem [Depth];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full = cnt_reg == (AW+1)'(Depth);
    assign nonempty = cnt_reg != '0;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + AW'(1);
            if (rd && nonempty)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr && !full) - (AW+1)'(rd && nonempty);
        end
    end
endmodule
`default_nettype wire

// ----- sv/u2a_back.sv -----
// Back end: serializes byte groups into single output bytes with run and text flags.
// Depends on u2a_pkg.
`default_nettype none
module u2a_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_nonempty,
    input  wire u2a_pkg::seq_t q_data,
    output logic               q_rd,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               text_last
);
    import u2a_pkg::*;

    logic [1:0] idx_reg;
    logic       last;

    assign empty = !q_nonempty;
    assign last = (idx_reg + 2'd1) == q_data.cnt;
    assign out_byte = q_data.bytes[idx_reg];
    assign run_last = last;
    assign text_last = last && q_data.eot;
    assign q_rd = pop && q_nonempty && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (pop && q_nonempty)
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
    end
endmodule
`default_nettype wire

// ----- sv/utf8_latin_to_ascii_folder.sv -----
// UTF-8 Latin letter folder, top level: front classifier, group queue, output serializer.
// Depends on u2a_pkg, u2a_front, u2a_queue, u2a_back.
// Accepted bytes' results are queued; out_byte reads the queue head combinationally.
// Throughput: one input byte per cycle while not full; output one byte per cycle
// while popped and not empty; N results of a byte take N pops. Queue depth sets slack.
// Reset (rst_n low, asynchronous) clears held bytes and empties the queue.
`default_nettype none
module utf8_latin_to_ascii_folder #(
    parameter int QDepth = u2a_pkg::QueueDepth
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            text_last
);
    import u2a_pkg::*;

    seq_t seq, q_data;
    logic q_full, q_nonempty, q_rd, wr;

    assign full = q_full;
    assign wr = push && !q_full && seq.cnt != 2'd0;

    u2a_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .in_byte(in_byte),
        .end_of_text(end_of_text), .take(!q_full), .seq(seq)
    );

    u2a_queue #(.Depth(QDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(wr), .wdata(seq), .full(q_full),
        .nonempty(q_nonempty), .rd(q_rd), .rdata(q_data)
    );

    u2a_back u_back (
        .clk(clk), .rst_n(rst_n), .q_nonempty(q_nonempty), .q_data(q_data),
        .q_rd(q_rd), .empty(empty), .pop(pop), .out_byte(out_byte),
        .run_last(run_last), .text_last(text_last)
    );
endmodule
`default_nettype wire
